@@ rtl/rwbc_pkg.sv @@
// Package: shared opcodes, state, event codes and control/status structs.
package rwbc_pkg;

  localparam int DATA_W = 64;

  typedef enum logic [5:0] {
    OP_CONST = 6'd0,  OP_MOVR  = 6'd1,  OP_MOVI  = 6'd2,  OP_ADDRR = 6'd3,
    OP_MULRR = 6'd4,  OP_EQRR  = 6'd5,  OP_NERR  = 6'd6,  OP_ADDRI = 6'd7,
    OP_MULRI = 6'd8,  OP_EQRI  = 6'd9,  OP_NERI  = 6'd10, OP_SUBRR = 6'd11,
    OP_DIVRR = 6'd12, OP_MODRR = 6'd13, OP_LTRR  = 6'd14, OP_LERR  = 6'd15,
    OP_SUBRI = 6'd16, OP_DIVRI = 6'd17, OP_MODRI = 6'd18, OP_LTRI  = 6'd19,
    OP_LERI  = 6'd20, OP_SUBIR = 6'd21, OP_DIVIR = 6'd22, OP_MODIR = 6'd23,
    OP_LTIR  = 6'd24, OP_LEIR  = 6'd25, OP_NEG   = 6'd26, OP_NOT   = 6'd27,
    OP_JMP   = 6'd28, OP_JT    = 6'd29, OP_JF    = 6'd30, OP_CALL  = 6'd31,
    OP_RETR  = 6'd32, OP_RETI  = 6'd33, OP_LOOP  = 6'd34, OP_EXIT  = 6'd35,
    OP_IN    = 6'd36, OP_OUT   = 6'd37
  } op_t;

  // First opcode with no meaning; it and all above it fault.
  localparam logic [5:0] OP_FIRST_BAD = 6'd38;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_OUT   = 2'd1,
    EV_EXIT  = 2'd2,
    EV_FAULT = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_OPER, ST_MUL, ST_DSTART, ST_DWAIT, ST_COMMIT
  } state_t;

  typedef struct packed {
    logic       clr_en;
    logic       load;
    logic       oper_cap;
    logic       mul_en;
    logic [1:0] mul_phase;
    logic       div_start;
    logic       commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_mul;
    logic is_div;
    logic y_zero;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/rwbc_if.sv @@
// Interfaces: instruction request channel and result channel.
interface rwbc_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         operation;
  logic [7:0]         reg_a;
  logic [7:0]         reg_b;
  logic [7:0]         reg_c;
  logic signed [15:0] imm_d;
  logic signed [63:0] const_word;
  logic signed [63:0] in_value;

  modport source (output valid, operation, reg_a, reg_b, reg_c, imm_d, const_word, in_value,
                  input ready);
  modport sink (input valid, operation, reg_a, reg_b, reg_c, imm_d, const_word, in_value,
                output ready);
endinterface

interface rwbc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        next_pc;
  logic [1:0]         event_res;
  logic signed [63:0] value;

  modport source (output valid, next_pc, event_res, value, input ready);
  modport sink (input valid, next_pc, event_res, value, output ready);
endinterface

@@ rtl/rwbc_div.sv @@
// Iterative unsigned 64-bit divider, one quotient bit per cycle.
module rwbc_div
  import rwbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic [DATA_W-1:0] quo,
  output logic [DATA_W-1:0] rem,
  output logic              done
);

  localparam int CNT_W = $clog2(DATA_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DATA_W-1:0] den_r;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   rem_sub;

  assign rem_sh  = {rem, quo[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (!rem_sub[DATA_W]) begin
        rem <= rem_sub[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/rwbc_ctrl.sv @@
// Controller: sequences clearing, operand read, multiply, divide and commit.
module rwbc_ctrl
  import rwbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t     state, state_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      phase <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    cmd           = '0;
    cmd.mul_phase = phase;
    in_ready      = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_OPER;
      ST_OPER: begin
        cmd.oper_cap = 1'b1;
        phase_next   = '0;
        if (stat.is_div && !stat.y_zero) state_next = ST_DSTART;
        else if (stat.is_mul)            state_next = ST_MUL;
        else                             state_next = ST_COMMIT;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        phase_next = phase + 1'b1;
        if (phase == 2'd2) state_next = ST_COMMIT;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat.div_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/rwbc_dp.sv @@
// Datapath: register file memory, operand registers, ALU, pc, window base and result register.
module rwbc_dp
  import rwbc_pkg::*;
#(
  parameter int REG_WORDS     = 16384,
  parameter int PROGRAM_WORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat,
  input  logic [5:0]         in_operation,
  input  logic [7:0]         in_reg_a,
  input  logic [7:0]         in_reg_b,
  input  logic [7:0]         in_reg_c,
  input  logic signed [15:0] in_imm_d,
  input  logic signed [63:0] in_const_word,
  input  logic signed [63:0] in_in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [15:0]        out_next_pc,
  output logic [1:0]         out_event_res,
  output logic signed [63:0] out_value
);

  localparam int RW   = $clog2(REG_WORDS);
  localparam int PC_W = $clog2(PROGRAM_WORDS);

  logic [DATA_W-1:0] mem [REG_WORDS];
  logic [DATA_W-1:0] rdata0, rdata1;

  op_t               op;
  logic [7:0]        ra, rb, rc;
  logic [15:0]       dimm;
  logic [DATA_W-1:0] kword, ivalue;
  logic [DATA_W-1:0] x, y, acc;
  logic              fault;
  logic [PC_W-1:0]   pc;
  logic [RW-1:0]     base;
  logic [RW-1:0]     clr_addr;

  logic [RW-1:0]     addr0, addr1;
  logic              is_bin, is_ri, is_ir, use_a, use_link;
  logic [DATA_W-1:0] x_sel, y_sel, d_ext;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       prod;
  logic [DATA_W-1:0] div_quo, div_rem, div_q_s, div_r_s;
  logic              div_done;

  logic              wr_en;
  logic [RW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [PC_W-1:0]   npc;
  logic [RW-1:0]     base_next;
  ev_t               ev;
  logic [DATA_W-1:0] val;

  // Decode of the latched opcode.
  always_comb begin
    is_bin   = op inside {[OP_ADDRR:OP_LEIR]};
    is_ri    = op inside {[OP_ADDRI:OP_NERI], [OP_SUBRI:OP_LERI]};
    is_ir    = op inside {[OP_SUBIR:OP_LEIR]};
    use_a    = op inside {OP_JT, OP_JF, OP_CALL, OP_RETR, OP_EXIT, OP_OUT};
    use_link = op inside {OP_RETR, OP_RETI};
  end

  assign addr0 = base + (use_a ? RW'(ra) : RW'(rb));
  assign addr1 = use_link ? base - 1'b1 : base + RW'(rc);
  assign d_ext = {{(DATA_W-16){dimm[15]}}, dimm};

  always_comb begin
    x_sel = (is_bin && is_ir) ? {{(DATA_W-8){rb[7]}}, rb} : rdata0;
    y_sel = (is_bin && is_ri) ? {{(DATA_W-8){rc[7]}}, rc} : rdata1;
  end

  always_comb begin
    stat.clr_last = (clr_addr == '1);
    stat.is_mul   = op inside {OP_MULRR, OP_MULRI};
    stat.is_div   = op inside {OP_DIVRR, OP_MODRR, OP_DIVRI, OP_MODRI, OP_DIVIR, OP_MODIR};
    stat.y_zero   = (y_sel == '0);
    stat.div_done = div_done;
    stat.out_free = !out_valid || out_ready;
  end

  // Register file: two registered read ports, one write port shared with the clearing pass.
  always_ff @(posedge clk) begin
    rdata0 <= mem[addr0];
    rdata1 <= mem[addr1];
    if (cmd.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.commit && wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_t'(in_operation);
      ra     <= in_reg_a;
      rb     <= in_reg_b;
      rc     <= in_reg_c;
      dimm   <= in_imm_d;
      kword  <= in_const_word;
      ivalue <= in_in_value;
    end
    if (cmd.oper_cap) begin
      x     <= x_sel;
      y     <= y_sel;
      fault <= (op >= OP_FIRST_BAD) || (stat.is_div && stat.y_zero);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == 2'd0) acc <= prod;
      else                       acc <= acc + {prod[31:0], 32'd0};
    end
  end

  // Low 64 bits of the product from three 32 x 32 partial products.
  always_comb begin
    case (cmd.mul_phase)
      2'd0:    begin mul_a = x[31:0];  mul_b = y[31:0];  end
      2'd1:    begin mul_a = x[31:0];  mul_b = y[63:32]; end
      default: begin mul_a = x[63:32]; mul_b = y[31:0];  end
    endcase
  end
  assign prod = mul_a * mul_b;

  rwbc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (x[DATA_W-1] ? -x : x),
    .den   (y[DATA_W-1] ? -y : y),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  assign div_q_s = (x[DATA_W-1] ^ y[DATA_W-1]) ? -div_quo : div_quo;
  assign div_r_s = x[DATA_W-1] ? -div_rem : div_rem;

  // Execution at commit.
  always_comb begin
    wr_en     = 1'b0;
    waddr     = base + RW'(ra);
    wdata     = '0;
    npc       = pc + 1'b1;
    base_next = base;
    ev        = EV_NONE;
    val       = '0;
    if (fault) begin
      ev  = EV_FAULT;
      npc = pc;
    end else begin
      case (op)
        OP_CONST: begin wr_en = 1'b1; wdata = kword; end
        OP_MOVR:  begin wr_en = 1'b1; wdata = x; end
        OP_MOVI:  begin wr_en = 1'b1; wdata = d_ext; end
        OP_ADDRR, OP_ADDRI: begin wr_en = 1'b1; wdata = x + y; end
        OP_MULRR, OP_MULRI: begin wr_en = 1'b1; wdata = acc; end
        OP_EQRR, OP_EQRI:   begin wr_en = 1'b1; wdata = DATA_W'(x == y); end
        OP_NERR, OP_NERI:   begin wr_en = 1'b1; wdata = DATA_W'(x != y); end
        OP_SUBRR, OP_SUBRI, OP_SUBIR: begin wr_en = 1'b1; wdata = x - y; end
        OP_DIVRR, OP_DIVRI, OP_DIVIR: begin wr_en = 1'b1; wdata = div_q_s; end
        OP_MODRR, OP_MODRI, OP_MODIR: begin wr_en = 1'b1; wdata = div_r_s; end
        OP_LTRR, OP_LTRI, OP_LTIR: begin
          wr_en = 1'b1;
          wdata = DATA_W'($signed(x) < $signed(y));
        end
        OP_LERR, OP_LERI, OP_LEIR: begin
          wr_en = 1'b1;
          wdata = DATA_W'(!($signed(y) < $signed(x)));
        end
        OP_NEG:  begin wr_en = 1'b1; wdata = -x; end
        OP_NOT:  begin wr_en = 1'b1; wdata = DATA_W'(x == '0); end
        OP_JMP:  npc = pc + dimm[PC_W-1:0] + 1'b1;
        OP_JT:   if (x != '0) npc = pc + dimm[PC_W-1:0] + 1'b1;
        OP_JF:   if (x == '0) npc = pc + dimm[PC_W-1:0] + 1'b1;
        OP_CALL: begin
          npc       = pc + x[PC_W-1:0] + 1'b1;
          wr_en     = 1'b1;
          wdata     = {24'd0, ra, 16'd0, 16'(pc)};
          base_next = base + RW'(ra) + 1'b1;
        end
        OP_RETR, OP_RETI: begin
          wr_en     = 1'b1;
          waddr     = base - 1'b1;
          wdata     = (op == OP_RETR) ? x : d_ext;
          base_next = base - (RW'(y[39:32]) + 1'b1);
          npc       = y[PC_W-1:0] + 1'b1;
        end
        OP_LOOP: ;
        OP_EXIT: begin ev = EV_EXIT; val = x; npc = pc; end
        OP_IN:   begin wr_en = 1'b1; wdata = ivalue; end
        OP_OUT:  begin ev = EV_OUT; val = x; end
        default: begin ev = EV_FAULT; npc = pc; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      base      <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_en) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        pc        <= npc;
        base      <= base_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_next_pc   <= 16'(npc);
      out_event_res <= ev;
      out_value     <= val;
    end
  end

endmodule

@@ rtl/register_window_bytecode_core.sv @@
// Top level of the register window bytecode core.
//
//  Channel | Direction | Payload                                          | Handshake
//  in_ch   | sink      | operation, reg_a, reg_b, reg_c, imm_d,           | valid/ready
//          |           | const_word, in_value                             |
//  out_ch  | source    | next_pc, event_res, value                        | valid/ready
//
// An instruction request passes through accept, register file read, operand
// capture and commit. Multiplies also pass through a shared 32 x 32 multiplier,
// and divide and modulo through the bit-serial divider, before commit.
// After reset the register file is swept to zero, one word a cycle, so no request
// is taken until the sweep is done. A stalled result holds only the commit of the
// next instruction; its request is already accepted and read meanwhile.
module register_window_bytecode_core
  import rwbc_pkg::*;
#(
  // Both sizes are to be powers of two (the core does not check it); indices then wrap modulo these sizes.
  parameter int REG_WORDS     = 16384,
  parameter int PROGRAM_WORDS = 65536
) (
  input logic         clk,
  input logic         rst,
  rwbc_in_if.sink     in_ch,
  rwbc_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // The controller decides when requests are taken and when results commit.
  rwbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds all architectural state and the result register.
  rwbc_dp #(
    .REG_WORDS     (REG_WORDS),
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_operation  (in_ch.operation),
    .in_reg_a      (in_ch.reg_a),
    .in_reg_b      (in_ch.reg_b),
    .in_reg_c      (in_ch.reg_c),
    .in_imm_d      (in_ch.imm_d),
    .in_const_word (in_ch.const_word),
    .in_in_value   (in_ch.in_value),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_next_pc   (out_ch.next_pc),
    .out_event_res (out_ch.event_res),
    .out_value     (out_ch.value)
  );

endmodule

@@ rtl/rwbc_checker.sv @@
// Checker on the top-level ports, bound to the core.
module rwbc_checker
  import rwbc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] next_pc,
  input logic [1:0]  event_res,
  input logic [63:0] value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(next_pc) && $stable(event_res) && $stable(value))
    else $error("result changed while stalled");

  a_quiet_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_NONE || event_res == EV_FAULT) |-> value == '0)
    else $error("value set on a result without output");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("request taken before the register file was cleared");

endmodule

bind register_window_bytecode_core rwbc_checker u_rwbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .next_pc   (out_ch.next_pc),
  .event_res (out_ch.event_res),
  .value     (out_ch.value)
);

@@ tb/tb_register_window_bytecode_core.sv @@
// Testbench for the register window bytecode core: predicts every result and checks it.
module tb_register_window_bytecode_core;
  import rwbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REGS = 16384;
  localparam int PWORDS = 65536;
  // Idle cycles with no request and no result moved before the run is given up. The clearing sweep
  // after reset moves nothing on either channel and a divide can sit behind a long result stall.
  localparam int WATCHDOG_LIMIT = 100000;

  typedef struct packed {
    logic [15:0] npc;
    logic [1:0]  ev;
    logic [63:0] val;
  } result_t;

  logic clk;
  logic rst;

  rwbc_in_if  instr_ch ();
  rwbc_out_if result_ch ();

  register_window_bytecode_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (instr_ch.sink),
    .out_ch (result_ch.source)
  );

  // Shadow copy of the machine state, advanced once for every accepted request.
  logic [63:0] shadow_regs [REGS];
  logic [15:0] shadow_pc;
  logic [13:0] shadow_base;

  result_t expected_results [$];
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      failed;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random; ready is redrawn at every rising edge.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result pc=%h ev=%0d val=%h", $time,
                 result_ch.next_pc, result_ch.event_res, result_ch.value);
        failed = 1'b1;
      end else begin
        exp_r = expected_results.pop_front();
        if (result_ch.next_pc !== exp_r.npc) begin
          $display("%0t: next_pc mismatch expected %h actual %h", $time, exp_r.npc,
                   result_ch.next_pc);
          failed = 1'b1;
        end
        if (result_ch.event_res !== exp_r.ev) begin
          $display("%0t: event_res mismatch expected %0d actual %0d", $time, exp_r.ev,
                   result_ch.event_res);
          failed = 1'b1;
        end
        if (result_ch.value !== exp_r.val) begin
          $display("%0t: value mismatch expected %h actual %h", $time, exp_r.val,
                   result_ch.value);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a request or a result.
  always @(posedge clk) begin
    if (rst || (instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [13:0] slot(input logic [7:0] off);
    return shadow_base + 14'(off);
  endfunction

  function automatic logic [63:0] sx8(input logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic logic signed [63:0] quot(input logic signed [63:0] x,
                                              input logic signed [63:0] y);
    // The minimum value over minus one wraps back to the minimum value.
    if (x == 64'sh8000000000000000 && y == -64'sd1) return x;
    return x / y;
  endfunction

  function automatic logic signed [63:0] remainder(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
    if (y == -64'sd1) return 64'sd0;
    return x % y;
  endfunction

  // Executes one instruction on the shadow state and returns the result it must produce.
  function automatic result_t execute_instr(input logic [5:0] op, input logic [7:0] a,
                                            input logic [7:0] b, input logic [7:0] c,
                                            input logic [15:0] d, input logic [63:0] kw,
                                            input logic [63:0] iv);
    result_t r;
    logic [63:0] x, y, dx, w, link, ret;
    logic [15:0] pc;
    logic is_ir, is_ri, div_op;
    logic [13:0] li;
    pc = shadow_pc;
    r.npc = pc + 16'd1;
    r.ev = EV_NONE;
    r.val = '0;
    dx = {{48{d[15]}}, d};
    x = '0;
    y = '0;
    div_op = 1'b0;
    if (op >= OP_ADDRR && op <= OP_LEIR) begin
      is_ir = (op >= OP_SUBIR);
      is_ri = (op >= OP_ADDRI && op <= OP_NERI) || (op >= OP_SUBRI && op <= OP_LERI);
      x = is_ir ? sx8(b) : shadow_regs[slot(b)];
      y = is_ri ? sx8(c) : shadow_regs[slot(c)];
      div_op = op inside {OP_DIVRR, OP_MODRR, OP_DIVRI, OP_MODRI, OP_DIVIR, OP_MODIR};
    end
    if (op >= OP_FIRST_BAD || (div_op && y == 0)) begin
      r.ev = EV_FAULT;
      r.npc = pc;
      return r;
    end
    case (op_t'(op))
      OP_CONST: shadow_regs[slot(a)] = kw;
      OP_MOVR: shadow_regs[slot(a)] = shadow_regs[slot(b)];
      OP_MOVI: shadow_regs[slot(a)] = dx;
      OP_ADDRR, OP_ADDRI: shadow_regs[slot(a)] = x + y;
      OP_MULRR, OP_MULRI: shadow_regs[slot(a)] = x * y;
      OP_EQRR, OP_EQRI: shadow_regs[slot(a)] = 64'(x == y);
      OP_NERR, OP_NERI: shadow_regs[slot(a)] = 64'(x != y);
      OP_SUBRR, OP_SUBRI, OP_SUBIR: shadow_regs[slot(a)] = x - y;
      OP_DIVRR, OP_DIVRI, OP_DIVIR: shadow_regs[slot(a)] = quot(x, y);
      OP_MODRR, OP_MODRI, OP_MODIR: shadow_regs[slot(a)] = remainder(x, y);
      OP_LTRR, OP_LTRI, OP_LTIR: shadow_regs[slot(a)] = 64'($signed(x) < $signed(y));
      OP_LERR, OP_LERI, OP_LEIR: shadow_regs[slot(a)] = 64'($signed(x) <= $signed(y));
      OP_NEG: shadow_regs[slot(a)] = -shadow_regs[slot(b)];
      OP_NOT: shadow_regs[slot(a)] = 64'(shadow_regs[slot(b)] == 0);
      OP_JMP: r.npc = pc + d + 16'd1;
      OP_JT: if (shadow_regs[slot(a)] != 0) r.npc = pc + d + 16'd1;
      OP_JF: if (shadow_regs[slot(a)] == 0) r.npc = pc + d + 16'd1;
      OP_CALL: begin
        w = shadow_regs[slot(a)];
        r.npc = pc + w[15:0] + 16'd1;
        shadow_regs[slot(a)] = {24'd0, a, 16'd0, pc};
        shadow_base = shadow_base + 14'(a) + 14'd1;
      end
      OP_RETR, OP_RETI: begin
        ret = (op == OP_RETR) ? shadow_regs[slot(a)] : dx;
        li = shadow_base - 14'd1;
        link = shadow_regs[li];
        shadow_regs[li] = ret;
        shadow_base = shadow_base - 14'(link[39:32]) - 14'd1;
        r.npc = link[15:0] + 16'd1;
      end
      OP_LOOP: ;
      OP_EXIT: begin
        r.ev = EV_EXIT;
        r.val = shadow_regs[slot(a)];
        r.npc = pc;
      end
      OP_IN: shadow_regs[slot(a)] = iv;
      OP_OUT: begin
        r.ev = EV_OUT;
        r.val = shadow_regs[slot(a)];
      end
      default: ;
    endcase
    shadow_pc = r.npc;
    return r;
  endfunction

  // Offers one request, with a random gap before it, and waits until it is accepted.
  // Valid stays high after acceptance until the next gap or drain lowers it.
  task automatic send_instr(input logic [5:0] op, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [15:0] d,
                            input logic [63:0] kw = 64'd0, input logic [63:0] iv = 64'd0);
    while ($urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid      <= 1'b1;
    instr_ch.operation  <= op;
    instr_ch.reg_a      <= a;
    instr_ch.reg_b      <= b;
    instr_ch.reg_c      <= c;
    instr_ch.imm_d      <= d;
    instr_ch.const_word <= kw;
    instr_ch.in_value   <= iv;
    do @(posedge clk); while (!instr_ch.ready);
    expected_results.insert(expected_results.size(), execute_instr(op, a, b, c, d, kw, iv));
  endtask

  task automatic wait_drained();
    instr_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Directed part: field extremes, a spread of opcodes, the division corner cases, faults,
  // a call and return pair, and an exit.
  task automatic test_directed();
    send_instr(OP_CONST, 8'd1, 8'd0, 8'd0, 16'hFFFF, 64'h8000000000000000);
    send_instr(OP_MOVI, 8'd2, 8'd0, 8'd0, 16'hFFFF);
    send_instr(OP_DIVRR, 8'd3, 8'd1, 8'd2, 16'd0);
    send_instr(OP_MODRR, 8'd4, 8'd1, 8'd2, 16'd0);
    send_instr(OP_DIVRI, 8'd5, 8'd1, 8'd0, 16'd0);
    send_instr(OP_MODIR, 8'd5, 8'd7, 8'd9, 16'd0);
    send_instr(OP_IN, 8'd255, 8'd0, 8'd0, 16'd0, 64'd0, 64'h7FFFFFFFFFFFFFFF);
    send_instr(OP_MULRR, 8'd6, 8'd255, 8'd255, 16'd0);
    send_instr(OP_DIVIR, 8'd7, 8'h80, 8'd2, 16'd0);
    send_instr(OP_LTIR, 8'd8, 8'h80, 8'd1, 16'd0);
    send_instr(OP_LERI, 8'd9, 8'd1, 8'h7F, 16'd0);
    send_instr(OP_NEG, 8'd10, 8'd1, 8'd0, 16'd0);
    send_instr(OP_NOT, 8'd11, 8'd0, 8'd0, 16'd0);
    send_instr(OP_OUT, 8'd255, 8'd0, 8'd0, 16'd0);
    send_instr(6'd63, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, '1, '1);
    send_instr(OP_FIRST_BAD, 8'd0, 8'd0, 8'd0, 16'd0);
    send_instr(OP_JMP, 8'd0, 8'd0, 8'd0, 16'h7FFF);
    send_instr(OP_JT, 8'd1, 8'd0, 8'd0, 16'h8000);
    send_instr(OP_JF, 8'd0, 8'd0, 8'd0, 16'd5);
    send_instr(OP_MOVI, 8'd20, 8'd0, 8'd0, 16'd3);
    send_instr(OP_CALL, 8'd20, 8'd0, 8'd0, 16'd0);
    send_instr(OP_RETI, 8'd0, 8'd0, 8'd0, 16'h8000);
    send_instr(OP_LOOP, 8'd0, 8'd0, 8'd0, 16'd0);
    send_instr(OP_EXIT, 8'd20, 8'd0, 8'd0, 16'd0);
    send_instr(OP_MOVR, 8'd21, 8'd20, 8'd0, 16'd0);
  endtask

  // Random part: mostly valid opcodes with small offsets so that registers get reused,
  // balanced calls and returns, and a sprinkling of full-range noise and bad opcodes.
  task automatic test_random(input int count);
    int depth;
    logic [5:0] op;
    logic [7:0] a, b, c;
    logic [15:0] d;
    depth = 0;
    for (int i = 0; i < count; i++) begin
      a = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
      b = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
      c = ($urandom_range(3) == 0) ? 8'($urandom()) : 8'($urandom_range(15));
      d = 16'($urandom());
      op = 6'($urandom_range(OP_OUT));
      if ($urandom_range(19) == 0) op = 6'($urandom_range(63, OP_FIRST_BAD));
      // Returns only pop a window that a call pushed, so links stay well formed.
      if ((op == OP_RETR || op == OP_RETI) && depth == 0) op = OP_LOOP;
      if (op == OP_CALL) begin
        if (depth >= 8) op = OP_LOOP;
        else begin
          a = 8'($urandom_range(7));
          send_instr(OP_MOVI, a, 8'd0, 8'd0, 16'($urandom_range(40)));
        end
      end
      if (op == OP_CALL) depth++;
      if (op == OP_RETR || op == OP_RETI) depth--;
      send_instr(op, a, b, c, d, rand64(), rand64());
    end
  endtask

  initial begin
    rst = 1'b1;
    failed = 1'b0;
    instr_ch.valid <= 1'b0;
    instr_ch.operation <= '0;
    instr_ch.reg_a <= '0;
    instr_ch.reg_b <= '0;
    instr_ch.reg_c <= '0;
    instr_ch.imm_d <= '0;
    instr_ch.const_word <= '0;
    instr_ch.in_value <= '0;
    shadow_pc = '0;
    shadow_base = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    send_idle_pct = 34;
    recv_idle_pct = 84;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(380);
    // The sender holds back until the core has delivered everything outstanding.
    wait_drained();
    send_idle_pct = 84;
    recv_idle_pct = 34;
    test_random(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(400);
    wait_drained();
    repeat (100) @(posedge clk);
    if (!failed && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
